>>> rtl/core/b32d_pkg.sv
package b32d_pkg;

   localparam int NUM_SYMBOLS = 32;
   localparam int NUM_REGS = 8;
   localparam int SYM_W = 5;
   localparam int CHAR_W = 8;
   localparam int REG_W = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int STORE_W = 7;
   localparam int HELD_W = 3;
   localparam int ACC_W = STORE_W + SYM_W;
   localparam int BYTE_BITS = 8;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] sym_regs_type;

   localparam sym_regs_type SYM_RESET = {
      32'h36353433, 32'h32315A59, 32'h58575655, 32'h54535251,
      32'h504F4E4D, 32'h4C4B4A49, 32'h48474645, 32'h44434241
   };

   typedef struct packed {
      logic             hit;
      logic [SYM_W-1:0] index;
   } lookup_type;

   typedef struct packed {
      logic             push;
      logic [SYM_W-1:0] index;
   } push_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

   function automatic lookup_type lookup_symbol(input sym_regs_type regs,
                                                input logic [CHAR_W-1:0] ch);
      lookup_type res;
      res.hit = 1'b0;
      res.index = '0;
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         if (regs[i / 4][(i % 4) * CHAR_W +: CHAR_W] == ch) begin
            res.hit = 1'b1;
            res.index = SYM_W'(i);
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/core/b32d_front.sv
module b32d_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [b32d_pkg::CHAR_W-1:0]      req_encoded_char,
   input  logic                             csr_valid,
   input  logic [b32d_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [b32d_pkg::REG_W-1:0]       csr_data,
   input  b32d_pkg::queue_status_type       queue_status,
   output b32d_pkg::push_type               push_out
);

   b32d_pkg::sym_regs_type sym_regs_ff;
   b32d_pkg::lookup_type   match;
   logic                   accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_regs_ff <= b32d_pkg::SYM_RESET;
      end else if (csr_valid &&
                   csr_index < b32d_pkg::CSR_INDEX_W'(b32d_pkg::NUM_REGS)) begin
         sym_regs_ff[csr_index[$clog2(b32d_pkg::NUM_REGS)-1:0]] <= csr_data;
      end
   end

   always_comb begin
      match = b32d_pkg::lookup_symbol(sym_regs_ff, req_encoded_char);
      accept = req_valid && !queue_status.full;
      // drop characters outside the alphabet
      push_out.push = accept && match.hit;
      push_out.index = match.index;
   end

endmodule

>>> rtl/core/b32d_queue.sv
module b32d_queue #(
   parameter int DEPTH = b32d_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  b32d_pkg::push_type           push_in,
   input  logic                         pop,
   output b32d_pkg::queue_status_type   status,
   output logic [b32d_pkg::SYM_W-1:0]   head_index
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [b32d_pkg::SYM_W-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       do_push, do_pop;

   always_comb begin
      status.full = (count_ff == CNT_W'(DEPTH));
      status.nonempty = (count_ff != '0);
      do_push = push_in.push && !status.full;
      do_pop = pop && status.nonempty;
      head_index = entries_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_in.index;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> !status.full)
      else $error("push into full queue");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");

endmodule

>>> rtl/core/b32d_back.sv
module b32d_back (
   input  logic                              clock,
   input  logic                              reset,
   input  b32d_pkg::queue_status_type        queue_status,
   input  logic [b32d_pkg::SYM_W-1:0]        head_index,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [b32d_pkg::BYTE_BITS-1:0]    rsp_decoded_byte
);

   logic [b32d_pkg::STORE_W-1:0]   store_ff, store_in;
   logic [b32d_pkg::HELD_W-1:0]    held_ff, held_in;
   logic                           out_valid_ff, out_valid_in;
   logic [b32d_pkg::BYTE_BITS-1:0] out_byte_ff, out_byte_in;
   logic [b32d_pkg::ACC_W-1:0]     acc;
   logic [b32d_pkg::HELD_W:0]      held_sum;
   logic [b32d_pkg::HELD_W-1:0]    rem;
   logic [b32d_pkg::ACC_W-1:0]     mask;

   always_comb begin
      pop = queue_status.nonempty && (!out_valid_ff || !rsp_stall);
      acc = {store_ff, head_index};
      held_sum = {1'b0, held_ff} + (b32d_pkg::HELD_W + 1)'(b32d_pkg::SYM_W);
      rem = held_sum[b32d_pkg::HELD_W-1:0];
      mask = (b32d_pkg::ACC_W'(1) << rem) - 1'b1;
      store_in = store_ff;
      held_in = held_ff;
      out_byte_in = out_byte_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (pop) begin
         held_in = rem;
         store_in = b32d_pkg::STORE_W'(acc & mask);
         if (held_sum[b32d_pkg::HELD_W]) begin
            out_valid_in = 1'b1;
            out_byte_in = b32d_pkg::BYTE_BITS'(acc >> rem);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         held_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         store_ff <= store_in;
         held_ff <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_decoded_byte = out_byte_ff;

   a_store_clean: assert property (@(posedge clock) disable iff (reset)
      (store_ff >> held_ff) == '0)
      else $error("bits above held count are set");

   a_byte_due: assert property (@(posedge clock) disable iff (reset)
      (pop && held_ff >= b32d_pkg::HELD_W'(3)) |=> out_valid_ff)
      else $error("full byte not emitted");

   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!out_valid_ff || !rsp_stall))
      else $error("pop while output slot blocked");

endmodule

>>> rtl/core/base32_stream_decoder_unit.sv
// Streaming base32 decoder with a programmable 32-character alphabet.
// Input channel req_*: one encoded character per word, accepted when req_valid
// is high and req_stall is low. Characters outside the alphabet are dropped
// without a result. Each matching character adds five bits; every full byte
// leaves on the rsp_* channel, oldest bits first. Leftover bits are kept.
// Configuration port csr_*: csr_index 0..7 selects the register holding four
// alphabet characters (lowest index in the low byte); csr_ready is always high
// and writes to higher indices are ignored. If a character appears twice,
// the highest index wins.
// A byte reaches rsp_* via the two-entry queue (written as the character
// completing it is accepted), then the accumulator and output register (on
// the pop). Throughput: one character per cycle unless rsp_stall holds the
// output, set by the single accumulator update per cycle in the back end.
// Reset: alphabet returns to "A".."Z","1".."6", the accumulator empties, the
// queue empties and the output valid flag is cleared.
// When rsp_stall holds, the output byte stays put, the queue fills, and
// req_stall rises once both queue entries are occupied.
module base32_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [b32d_pkg::CHAR_W-1:0]      req_encoded_char,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [b32d_pkg::BYTE_BITS-1:0]   rsp_decoded_byte,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [b32d_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [b32d_pkg::REG_W-1:0]       csr_data
);

   b32d_pkg::push_type         push;
   b32d_pkg::queue_status_type queue_status;
   logic [b32d_pkg::SYM_W-1:0] head_index;
   logic                       pop;

   assign csr_ready = 1'b1;
   assign req_stall = queue_status.full;

   b32d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_encoded_char (req_encoded_char),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .queue_status     (queue_status),
      .push_out         (push)
   );

   b32d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .pop        (pop),
      .status     (queue_status),
      .head_index (head_index)
   );

   b32d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .head_index       (head_index),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte)
   );

endmodule

>>> tb/tb_top.sv
class decode_tracker;
   b32d_pkg::sym_regs_type alphabet;
   logic [11:0]            bit_store;
   logic [3:0]             bits_held;
   logic [7:0]             bytes_due[$];
   int                     chars_taken;
   int                     symbols_hit;
   int                     bytes_checked;
   int                     mismatches;

   function new();
      alphabet = b32d_pkg::SYM_RESET;
      bit_store = '0;
      bits_held = '0;
      chars_taken = 0;
      symbols_hit = 0;
      bytes_checked = 0;
      mismatches = 0;
   endfunction

   function void set_reg(logic [7:0] idx, logic [31:0] data);
      if (idx < b32d_pkg::NUM_REGS) begin
         alphabet[idx] = data;
      end
   endfunction

   function logic [7:0] symbol_char(int idx);
      return alphabet[idx / 4][(idx % 4) * 8 +: 8];
   endfunction

   function void take_char(logic [7:0] ch);
      bit          hit;
      logic [4:0]  sym;
      logic [11:0] acc;
      logic [3:0]  held;
      hit = 1'b0;
      sym = '0;
      chars_taken++;
      // highest matching index wins
      for (int i = 0; i < b32d_pkg::NUM_SYMBOLS; i++) begin
         if (symbol_char(i) == ch) begin
            hit = 1'b1;
            sym = 5'(i);
         end
      end
      if (!hit) begin
         return;
      end
      symbols_hit++;
      acc = {bit_store[6:0], sym};
      held = bits_held + 4'd5;
      if (held >= 4'd8) begin
         held = held - 4'd8;
         bytes_due.push_back(8'(acc >> held));
      end
      bit_store = acc & ((12'd1 << held) - 12'd1);
      bits_held = held;
   endfunction

   function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (bytes_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("decoded byte %02h arrived with none due", got);
         end
         return;
      end
      want = bytes_due.pop_front();
      bytes_checked++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("decoded byte mismatch: expected %02h, got %02h", want, got);
         end
      end
   endfunction
endclass

module tb_top;

   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT = 2000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [b32d_pkg::CHAR_W-1:0]      req_encoded_char = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [b32d_pkg::BYTE_BITS-1:0]   rsp_decoded_byte;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [b32d_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [b32d_pkg::REG_W-1:0]       csr_data = '0;

   decode_tracker tracker;
   bit            steady = 1'b0;
   int            quiet_cycles = 0;
   int            settings_used = 0;

   base32_stream_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_encoded_char (req_encoded_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 15);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.take_char(req_encoded_char);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_byte(rsp_decoded_byte);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_char(input logic [b32d_pkg::CHAR_W-1:0] ch);
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_encoded_char <= ch;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every due byte has left, then let the queue empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [b32d_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [b32d_pkg::REG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_alphabet(input b32d_pkg::sym_regs_type regs);
      for (int r = 0; r < b32d_pkg::NUM_REGS; r++) begin
         write_reg(b32d_pkg::CSR_INDEX_W'(r), regs[r]);
      end
      settings_used++;
   endtask

   function automatic b32d_pkg::sym_regs_type random_alphabet(input bit crowded);
      b32d_pkg::sym_regs_type regs;
      for (int r = 0; r < b32d_pkg::NUM_REGS; r++) begin
         for (int b = 0; b < 4; b++) begin
            regs[r][b * 8 +: 8] = crowded ? 8'("A" + $urandom_range(0, 7))
                                          : 8'($urandom_range(0, 255));
         end
      end
      return regs;
   endfunction

   // mostly alphabet characters, the rest raw noise
   task automatic run_chars(input int picks);
      int sent;
      sent = 0;
      while (sent < picks) begin
         if ($urandom_range(0, 99) < 80) begin
            send_char(tracker.symbol_char($urandom_range(0, b32d_pkg::NUM_SYMBOLS - 1)));
         end else begin
            send_char(8'($urandom_range(0, 255)));
         end
         sent++;
      end
   endtask

   initial begin
      string opening;
      opening = "MZXW6YTBOI";
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_char(8'h00);
      send_char(8'hFF);
      send_char("A");
      send_char("7");
      send_char("a");
      for (int k = 0; k < opening.len(); k++) begin
         send_char(opening[k]);
      end
      send_char("=");
      repeat (3) send_char("7");
      settle();

      write_alphabet(random_alphabet(1'b0));
      write_reg(8'hFF, 32'hFFFF_FFFF);
      run_chars(150);
      settle();
      run_chars(150);
      settle();

      write_alphabet(random_alphabet(1'b1));
      run_chars(200);
      settle();

      write_alphabet('0);
      run_chars(40);
      settle();

      write_alphabet('1);
      run_chars(40);
      settle();

      steady = 1'b1;
      write_alphabet(random_alphabet(1'b0));
      run_chars(350);
      settle();
      steady = 1'b0;

      write_alphabet(b32d_pkg::SYM_RESET);
      write_reg(b32d_pkg::CSR_INDEX_W'(b32d_pkg::NUM_REGS), 32'h0000_0000);
      write_reg(b32d_pkg::CSR_INDEX_W'($urandom_range(b32d_pkg::NUM_REGS, 255)),
                32'($urandom));
      run_chars(350);
      settle();

      $display("decoded %0d bytes from %0d characters, %0d of them in the alphabet,",
               tracker.bytes_checked, tracker.chars_taken, tracker.symbols_hit);
      $display("across %0d alphabet settings including all-zero, all-one and duplicates",
               settings_used + 1);
      if (tracker.mismatches == 0 && tracker.bytes_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
